### src/tfdt_pkg.sv
// Shared types and constants for the triangle fragment depth test.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tfdt_pkg;
  localparam int WW = 16;
  localparam logic [16:0] ONE_Q15 = 17'd32768;
  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic               covered;
    logic        [22:0] det;
    logic        [22:0] num_a;
    logic        [22:0] num_b;
    logic signed [15:0] depth_a;
    logic signed [15:0] depth_b;
    logic signed [15:0] depth_c;
    logic        [16:0] addr_raw;
  } task_t;

  typedef struct packed {
    logic covered;
    logic written;
    logic [15:0] weight_a;
    logic [15:0] weight_b;
    logic [15:0] weight_c;
    logic signed [15:0] depth;
  } result_t;
endpackage
`default_nettype wire

### src/tfdt_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tfdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/tfdt_divider.sv
// Radix-2 restoring divider: quotient of (num << 15) / den, one bit a cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module tfdt_divider (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [22:0] num,
  input  wire  [22:0] den,
  output logic        busy,
  output logic        done,
  output logic [15:0] quot
);
  logic [37:0] dividend;
  logic [23:0] rem;
  logic [22:0] dsr;
  logic [5:0]  count;
  logic [23:0] trial;
  logic [37:0] q;

  assign trial = {rem[22:0], dividend[37]} - {1'b0, dsr};
  assign quot = q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd38;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {num, 15'd0};
      dsr <= den;
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      dividend <= {dividend[36:0], 1'b0};
      if (!trial[23]) begin
        rem <= trial;
        q <= {q[36:0], 1'b1};
      end else begin
        rem <= {rem[22:0], dividend[37]};
        q <= {q[36:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### src/tfdt_front.sv
// Front end: bounding box, edge functions and coverage for one pixel.
// Depends on tfdt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfdt_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [8:0]          width,
  input  wire  [8:0]          height,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  signed [10:0]  ax, ay, bx, by, cx, cy,
  input  wire  signed [15:0]  da, db, dc,
  input  wire  [7:0]          px, py,
  output logic                out_valid,
  input  wire                 out_ready,
  output tfdt_pkg::task_t     out_task
);
  import tfdt_pkg::*;
  // stage 1 registers
  logic s1_valid;
  logic s1_box;
  logic signed [11:0] acx, acy, bcx, bcy, pcx, pcy;
  logic signed [15:0] s1_da, s1_db, s1_dc;
  logic [16:0] s1_addr;
  logic signed [10:0] xmin, xmax, ymin, ymax;
  logic box_ok;
  logic signed [24:0] det_s, na_s, nb_s;
  logic signed [24:0] det_n, na_n, nb_n;
  logic [25:0] sum_ab;
  logic cov;

  always_comb begin
    xmin = ax; if (bx < xmin) xmin = bx; if (cx < xmin) xmin = cx;
    xmax = ax; if (bx > xmax) xmax = bx; if (cx > xmax) xmax = cx;
    ymin = ay; if (by < ymin) ymin = by; if (cy < ymin) ymin = cy;
    ymax = ay; if (by > ymax) ymax = by; if (cy > ymax) ymax = cy;
    box_ok = !xmin[10] && !ymin[10] &&
             ($signed({1'b0, xmax}) < $signed({3'b0, width})) &&
             ($signed({1'b0, ymax}) < $signed({3'b0, height})) &&
             ($signed({4'b0, px}) >= xmin) && ($signed({4'b0, px}) < xmax) &&
             ($signed({4'b0, py}) >= ymin) && ($signed({4'b0, py}) < ymax);
  end

  // advance both stages together; hold everything while the output waits
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (in_ready) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_box <= box_ok;
      acx <= 12'(ax) - 12'(cx);
      acy <= 12'(ay) - 12'(cy);
      bcx <= 12'(bx) - 12'(cx);
      bcy <= 12'(by) - 12'(cy);
      pcx <= $signed({4'b0, px}) - 12'(cx);
      pcy <= $signed({4'b0, py}) - 12'(cy);
      s1_da <= da; s1_db <= db; s1_dc <= dc;
      s1_addr <= 17'(py * width) + 17'(px);
    end
  end

  always_comb begin
    det_s = 25'(acx * bcy) - 25'(acy * bcx);
    na_s = 25'(pcx * bcy) - 25'(pcy * bcx);
    nb_s = 25'(pcy * acx) - 25'(pcx * acy);
    if (det_s < 0) begin
      det_n = -det_s; na_n = -na_s; nb_n = -nb_s;
    end else begin
      det_n = det_s; na_n = na_s; nb_n = nb_s;
    end
    sum_ab = 26'(na_n) + 26'(nb_n);
    cov = s1_box && det_n != 0 && !na_n[24] && !nb_n[24] &&
          $signed(sum_ab) <= $signed(26'(det_n));
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && s1_valid) begin
      out_task.covered <= cov;
      out_task.det <= det_n[22:0];
      out_task.num_a <= na_n[22:0];
      out_task.num_b <= nb_n[22:0];
      out_task.depth_a <= s1_da;
      out_task.depth_b <= s1_db;
      out_task.depth_c <= s1_dc;
      out_task.addr_raw <= s1_addr;
    end
  end
endmodule
`default_nettype wire

### src/tfdt_back.sv
// Back end: weight division, depth interpolation and z-buffer update.
// Depends on tfdt_pkg, tfdt_divider and tfdt_ram.
`timescale 1ns / 1ps
`default_nettype none
module tfdt_back #(
  parameter int MAX_PIXELS = 65536,
  parameter int DEPTH_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  tfdt_pkg::task_t    in_task,
  output logic               res_valid,
  input  wire                res_ready,
  output tfdt_pkg::result_t  res
);
  import tfdt_pkg::*;
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_DIVA = 4'd2,
    ST_DIVB = 4'd3, ST_MUL = 4'd4, ST_SUM = 4'd5, ST_READ = 4'd6,
    ST_CMP = 4'd7, ST_OUT = 4'd8;

  logic [3:0] state;
  logic [AW:0] clr;
  task_t t;
  logic [15:0] wa, wb;
  logic [16:0] wc;
  logic signed [33:0] pa, pb, pc;
  logic signed [35:0] zsum;
  logic signed [DEPTH_BITS-1:0] z;
  logic div_start, div_busy, div_done;
  logic [15:0] div_q;
  logic [22:0] div_num;
  logic we;
  logic [AW-1:0] waddr, addr;
  logic [DEPTH_BITS-1:0] wdata, rdata;
  logic signed [35:0] zr;
  logic signed [DEPTH_BITS-1:0] zsat;
  logic pass;
  logic res_set;

  localparam logic signed [35:0] DMAX = 36'((64'sd1 <<< (DEPTH_BITS - 1)) - 1);
  localparam logic signed [35:0] DMIN = -36'(64'sd1 <<< (DEPTH_BITS - 1));

  assign addr = AW'(t.addr_raw % 17'(MAX_PIXELS));
  assign div_num = (state == ST_IDLE) ? in_task.num_a : t.num_b;
  assign div_start = (state == ST_IDLE && in_valid && in_task.covered) ||
                     (state == ST_DIVA && div_done);

  tfdt_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den((state == ST_IDLE) ? in_task.det : t.det),
    .busy(div_busy), .done(div_done), .quot(div_q)
  );

  tfdt_ram #(.WIDTH(DEPTH_BITS), .DEPTH(2 ** AW)) u_zbuf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    zr = (zsum + 36'sd16384) >>> 15;
    if (zr > DMAX) zsat = DEPTH_BITS'(DMAX);
    else if (zr < DMIN) zsat = DEPTH_BITS'(DMIN);
    else zsat = DEPTH_BITS'(zr);
    pass = $signed(z) >= $signed(rdata);
    we = (state == ST_CLEAR) || (state == ST_CMP && pass);
    waddr = (state == ST_CLEAR) ? clr[AW-1:0] : addr;
    wdata = (state == ST_CLEAR) ? {1'b1, {(DEPTH_BITS-1){1'b0}}} : z;
  end

  // a result leaving this cycle frees the output for the next transaction
  assign in_ready = (state == ST_IDLE) && (!res_valid || res_ready);
  assign res_set = (state == ST_IDLE && in_ready && in_valid && !in_task.covered) ||
                   (state == ST_CMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_set) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(2 ** AW - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_ready && in_valid) begin
            t <= in_task;
            if (in_task.covered) state <= ST_DIVA;
            else res <= '0;
          end
        end
        ST_DIVA: if (div_done) begin wa <= div_q; state <= ST_DIVB; end
        ST_DIVB: if (div_done) begin
          wb <= div_q;
          wc <= ONE_Q15 - 17'(wa) - 17'(div_q);
          state <= ST_MUL;
        end
        ST_MUL: begin
          pa <= $signed({2'b0, wa}) * t.depth_a;
          pb <= $signed({2'b0, wb}) * t.depth_b;
          pc <= $signed({1'b0, wc}) * t.depth_c;
          state <= ST_SUM;
        end
        ST_SUM: begin
          zsum <= 36'(pa) + 36'(pb) + 36'(pc);
          state <= ST_READ;
        end
        ST_READ: begin
          z <= zsat;
          state <= ST_CMP;
        end
        ST_CMP: begin
          res.covered <= 1'b1;
          res.written <= pass;
          res.weight_a <= wa;
          res.weight_b <= wb;
          res.weight_c <= wc[15:0];
          res.depth <= 16'(z);
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = div_busy;
endmodule
`default_nettype wire

### src/triangle_fragment_depth_test.sv
// Top level of the triangle fragment depth test.
// Depends on tfdt_pkg, tfdt_front and tfdt_back.
`timescale 1ns / 1ps
`default_nettype none
// A pixel enters through the push/full port; the front end computes the box and
// edge tests in two stages, a two-entry queue feeds the back end, which divides
// the two weights with a bit-serial divider and updates the z-buffer RAM. The
// back end takes no new pixel until the previous covered one has passed the
// depth compare; uncovered pixels' results can follow one per cycle when popped.
// After reset the z-buffer is cleared one entry a cycle, all MAX_PIXELS entries
// (rounded up to a power of two), before items are taken.
module triangle_fragment_depth_test #(
  parameter int MAX_PIXELS = 65536,
  parameter int DEPTH_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire  signed [10:0] vertex_a_x,
  input  wire  signed [10:0] vertex_a_y,
  input  wire  signed [10:0] vertex_b_x,
  input  wire  signed [10:0] vertex_b_y,
  input  wire  signed [10:0] vertex_c_x,
  input  wire  signed [10:0] vertex_c_y,
  input  wire  signed [15:0] vertex_a_depth,
  input  wire  signed [15:0] vertex_b_depth,
  input  wire  signed [15:0] vertex_c_depth,
  input  wire  [7:0]         pixel_x,
  input  wire  [7:0]         pixel_y,
  output logic               empty,
  input  wire                pop,
  output logic               covered,
  output logic               depth_written,
  output logic [15:0]        weight_a,
  output logic [15:0]        weight_b,
  output logic [15:0]        weight_c,
  output logic signed [15:0] fragment_depth,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [0:0]         cfg_index,
  input  wire  [8:0]         cfg_data
);
  import tfdt_pkg::*;
  logic [8:0] screen_width, screen_height;
  logic f_valid, f_ready, in_ready;
  task_t f_task, q_task [2];
  logic [1:0] q_count;
  logic q_rd, q_wr;
  logic b_ready, r_valid;
  result_t r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 9'd256;
      screen_height <= 9'd256;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) screen_width <= cfg_data;
      if (cfg_index == REG_HEIGHT) screen_height <= cfg_data;
    end
  end

  assign full = !in_ready;

  tfdt_front u_front (
    .clk(clk), .rst(rst), .width(screen_width), .height(screen_height),
    .in_valid(push), .in_ready(in_ready),
    .ax(vertex_a_x), .ay(vertex_a_y), .bx(vertex_b_x), .by(vertex_b_y),
    .cx(vertex_c_x), .cy(vertex_c_y),
    .da(vertex_a_depth), .db(vertex_b_depth), .dc(vertex_c_depth),
    .px(pixel_x), .py(pixel_y),
    .out_valid(f_valid), .out_ready(f_ready), .out_task(f_task)
  );

  // two-entry queue between front and back
  assign f_ready = q_count != 2'd2;
  assign q_wr = f_valid && f_ready;
  assign q_rd = (q_count != 2'd0) && b_ready;
  always_ff @(posedge clk) begin
    if (rst) q_count <= '0;
    else q_count <= q_count + 2'(q_wr) - 2'(q_rd);
  end
  always_ff @(posedge clk) begin
    if (q_wr && (q_rd ? q_count == 2'd1 : q_count == 2'd0)) q_task[0] <= f_task;
    else if (q_rd) q_task[0] <= q_task[1];
    if (q_wr && !q_rd && q_count == 2'd1) q_task[1] <= f_task;
  end

  tfdt_back #(.MAX_PIXELS(MAX_PIXELS), .DEPTH_BITS(DEPTH_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_count != 2'd0), .in_ready(b_ready),
    .in_task(q_task[0]), .res_valid(r_valid), .res_ready(pop), .res(r)
  );

  assign empty = !r_valid;
  assign covered = r.covered;
  assign depth_written = r.written;
  assign weight_a = r.weight_a;
  assign weight_b = r.weight_b;
  assign weight_c = r.weight_c;
  assign fragment_depth = r.depth;

`ifndef SYNTHESIS
  a_written_covered: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!depth_written || covered)) else $error("write without cover");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3) else $error("queue overflow");
  a_uncov_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !covered) |-> (weight_a == 16'd0 && fragment_depth == 16'sd0))
    else $error("uncovered result not zero");
`endif
endmodule
`default_nettype wire
